>>> hdl/gbo_pkg.sv
// ----------------------------------------------------------------------------
// gbo_pkg
// Shared types and codes for the breadth-first visit order block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbo_pkg;

   localparam int NODE_W  = 6;
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 7;
   localparam int ID_CAP  = 64;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_APPEND = 9'b000000010,
      S_INIT   = 9'b000000100,
      S_POP    = 9'b000001000,
      S_CUR    = 9'b000010000,
      S_DEG    = 9'b000100000,
      S_RD     = 9'b001000000,
      S_CHK    = 9'b010000000,
      S_EMIT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic capture;
      logic append_wr;
      logic clear_graph;
      logic run_init;
      logic pop;
      logic load_cur;
      logic load_deg;
      logic rd_edge;
      logic chk_edge;
      logic emit;
   } ctrl_type;

   typedef struct packed {
      logic scan_done;
      logic queue_empty;
      logic rsp_stall;
   } status_type;

endpackage

`default_nettype wire

>>> hdl/gbo_ctrl.sv
// ----------------------------------------------------------------------------
// gbo_ctrl
// Sequencer for append, clear and breadth-first run commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbo_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [gbo_pkg::CMD_W-1:0]  req_cmd,
   input  wire gbo_pkg::status_type        sts,
   output gbo_pkg::ctrl_type               ctl
);

   gbo_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbo_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         gbo_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               unique case (req_cmd)
                  gbo_pkg::CMD_APPEND: state_in = gbo_pkg::S_APPEND;
                  gbo_pkg::CMD_RUN:    state_in = gbo_pkg::S_INIT;
                  gbo_pkg::CMD_CLEAR:  ctl.clear_graph = 1'b1;
                  default: ;
               endcase
            end
         end
         gbo_pkg::S_APPEND: begin
            ctl.append_wr = 1'b1;
            state_in      = gbo_pkg::S_IDLE;
         end
         gbo_pkg::S_INIT: begin
            ctl.run_init = 1'b1;
            state_in     = gbo_pkg::S_POP;
         end
         gbo_pkg::S_POP: begin
            ctl.pop  = 1'b1;
            state_in = gbo_pkg::S_CUR;
         end
         gbo_pkg::S_CUR: begin
            ctl.load_cur = 1'b1;
            state_in     = gbo_pkg::S_DEG;
         end
         gbo_pkg::S_DEG: begin
            ctl.load_deg = 1'b1;
            state_in     = gbo_pkg::S_RD;
         end
         gbo_pkg::S_RD: begin
            if (sts.scan_done) begin
               state_in = gbo_pkg::S_EMIT;
            end else begin
               ctl.rd_edge = 1'b1;
               state_in    = gbo_pkg::S_CHK;
            end
         end
         gbo_pkg::S_CHK: begin
            ctl.chk_edge = 1'b1;
            state_in     = gbo_pkg::S_RD;
         end
         gbo_pkg::S_EMIT: begin
            if (!sts.rsp_stall) begin
               ctl.emit = 1'b1;
               state_in = sts.queue_empty ? gbo_pkg::S_IDLE : gbo_pkg::S_POP;
            end
         end
         default: state_in = gbo_pkg::S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/gbo_datapath.sv
// ----------------------------------------------------------------------------
// gbo_datapath
// Adjacency store, degree table, visit queue and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbo_datapath #(
   parameter int MAX_NODES  = 64,
   parameter int MAX_DEGREE = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gbo_pkg::ctrl_type             ctl,
   output gbo_pkg::status_type                sts,
   input  wire logic [gbo_pkg::NODE_W-1:0]    req_node,
   input  wire logic [gbo_pkg::NODE_W-1:0]    req_neighbor,
   input  wire logic                          csr_we,
   input  wire logic [gbo_pkg::COUNT_W-1:0]   csr_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [gbo_pkg::NODE_W-1:0]         rsp_visit_node,
   output logic                               rsp_last,
   output logic                               rsp_dropped
);

   localparam int ROWS = (MAX_NODES < gbo_pkg::ID_CAP) ? MAX_NODES : gbo_pkg::ID_CAP;
   localparam int RW   = $clog2(ROWS);
   localparam int DW   = $clog2(MAX_DEGREE + 1);
   localparam int AW   = $clog2(ROWS * MAX_DEGREE);
   localparam int QW   = $clog2(ROWS + 1);
   localparam int NW   = gbo_pkg::NODE_W;
   localparam int CW   = gbo_pkg::COUNT_W;
   localparam logic [CW-1:0] CAP_C  = CW'(ROWS);
   localparam logic [DW-1:0] MAXD_C = DW'(MAX_DEGREE);
   localparam logic [AW-1:0] STEP_C = AW'(MAX_DEGREE);
   localparam logic [QW-1:0] QCAP_C = QW'(ROWS);

   // memories
   logic [NW-1:0] store_mem [ROWS*MAX_DEGREE];
   logic [DW-1:0] deg_mem   [ROWS];
   logic [RW-1:0] queue_mem [ROWS];

   logic [NW-1:0] store_rdata_ff;
   logic [DW-1:0] deg_rdata_ff;
   logic          deg_rvld_ff;
   logic [RW-1:0] queue_rdata_ff;

   logic [ROWS-1:0] deg_vld_ff;
   logic [ROWS-1:0] visited_ff;
   logic [CW-1:0]   node_count_ff;
   logic            drop_ff;
   logic [NW-1:0]   node_ff;
   logic [NW-1:0]   nb_ff;
   logic [RW-1:0]   cur_ff;
   logic [DW-1:0]   deg_ff;
   logic [DW-1:0]   k_ff;
   logic [QW-1:0]   head_ff;
   logic [QW-1:0]   tail_ff;
   logic            rsp_valid_ff;
   logic [NW-1:0]   rsp_node_ff;
   logic            rsp_last_ff;
   logic            rsp_drop_ff;

   logic [CW-1:0] n_eff;
   logic [DW-1:0] deg_now;
   logic          append_bad;
   logic [RW-1:0] deg_raddr;
   logic [AW-1:0] store_waddr;
   logic [AW-1:0] store_raddr;
   logic [CW-1:0] nxt_ext;
   logic          nxt_take;
   logic [RW-1:0] nxt_idx;

   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = CW'(1);
      end else if (node_count_ff > CAP_C) begin
         n_eff = CAP_C;
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign deg_now     = deg_rvld_ff ? deg_rdata_ff : '0;
   assign append_bad  = (CW'(node_ff) >= n_eff) || (CW'(nb_ff) >= n_eff) ||
                        (deg_now >= MAXD_C);
   assign deg_raddr   = ctl.capture ? req_node[RW-1:0] : queue_rdata_ff;
   assign store_waddr = AW'(AW'(node_ff[RW-1:0]) * STEP_C + AW'(deg_now));
   assign store_raddr = AW'(AW'(cur_ff) * STEP_C + AW'(k_ff));
   assign nxt_ext     = CW'(store_rdata_ff);
   assign nxt_idx     = store_rdata_ff[RW-1:0];
   assign nxt_take    = (nxt_ext < n_eff) && !visited_ff[nxt_idx] && (tail_ff < QCAP_C);

   assign sts.scan_done   = (k_ff >= deg_ff);
   assign sts.queue_empty = (head_ff == tail_ff);
   assign sts.rsp_stall   = rsp_valid_ff && !rsp_ready;

   // memory ports
   always_ff @(posedge clock) begin
      if (ctl.append_wr && !append_bad) begin
         store_mem[store_waddr]       <= nb_ff;
         deg_mem[node_ff[RW-1:0]]     <= deg_now + DW'(1);
      end
      if (ctl.run_init) begin
         queue_mem[RW'(0)] <= '0;
      end else if (ctl.chk_edge && nxt_take) begin
         queue_mem[tail_ff[RW-1:0]] <= nxt_idx;
      end
      if (ctl.rd_edge) begin
         store_rdata_ff <= store_mem[store_raddr];
      end
      deg_rdata_ff   <= deg_mem[deg_raddr];
      deg_rvld_ff    <= deg_vld_ff[deg_raddr];
      queue_rdata_ff <= queue_mem[head_ff[RW-1:0]];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_vld_ff    <= '0;
         visited_ff    <= '0;
         node_count_ff <= gbo_pkg::NODE_COUNT_RESET;
         drop_ff       <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            node_count_ff <= csr_data;
         end
         if (ctl.clear_graph) begin
            deg_vld_ff <= '0;
            drop_ff    <= 1'b0;
         end else if (ctl.append_wr) begin
            if (append_bad) begin
               drop_ff <= 1'b1;
            end else begin
               deg_vld_ff[node_ff[RW-1:0]] <= 1'b1;
            end
         end
         if (ctl.run_init) begin
            visited_ff    <= ROWS'(1);
            head_ff       <= '0;
            tail_ff       <= QW'(1);
         end else begin
            if (ctl.pop) begin
               head_ff <= head_ff + QW'(1);
            end
            if (ctl.chk_edge && nxt_take) begin
               visited_ff[nxt_idx] <= 1'b1;
               tail_ff             <= tail_ff + QW'(1);
            end
         end
         if (ctl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         node_ff <= req_node;
         nb_ff   <= req_neighbor;
      end
      if (ctl.load_cur) begin
         cur_ff <= queue_rdata_ff;
      end
      if (ctl.load_deg) begin
         deg_ff <= deg_now;
         k_ff   <= '0;
      end else if (ctl.chk_edge) begin
         k_ff <= k_ff + DW'(1);
      end
      if (ctl.emit) begin
         rsp_node_ff <= NW'(cur_ff);
         rsp_last_ff <= (head_ff == tail_ff);
         rsp_drop_ff <= drop_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_visit_node = rsp_node_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_dropped    = rsp_drop_ff;

endmodule

`default_nettype wire

>>> hdl/graph_breadth_first_order.sv
// ----------------------------------------------------------------------------
// graph_breadth_first_order
// Directed adjacency list with a breadth-first visit order search from node 0.
// ----------------------------------------------------------------------------
//  channel  ports                                  direction
//  req      req_cmd, req_node, req_neighbor        in
//  rsp      rsp_visit_node, rsp_last, rsp_dropped  out
//  csr      csr_data (node_count)                  in
//
//  append: degree table read, then store write
//  clear and unknown commands finish in S_IDLE; clear empties all lists at once
//  run: init, then per visited node pop, current, degree, a read and a check per
//    scanned edge, and emit, in step with the queue, degree and store read ports
//  a stalled rsp beat holds the search at its next result; reset needs no sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module graph_breadth_first_order #(
   parameter int MAX_NODES  = 64,
   parameter int MAX_DEGREE = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [gbo_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [gbo_pkg::NODE_W-1:0]       req_node,
   input  wire logic [gbo_pkg::NODE_W-1:0]       req_neighbor,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [gbo_pkg::NODE_W-1:0]            rsp_visit_node,
   output logic                                  rsp_last,
   output logic                                  rsp_dropped,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gbo_pkg::COUNT_W-1:0]      csr_data
);

   gbo_pkg::ctrl_type   ctl;
   gbo_pkg::status_type sts;

   assign csr_ready = 1'b1;

   gbo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .sts       (sts),
      .ctl       (ctl)
   );

   gbo_datapath #(
      .MAX_NODES  (MAX_NODES),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_node       (req_node),
      .req_neighbor   (req_neighbor),
      .csr_we         (csr_valid & csr_ready),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_visit_node (rsp_visit_node),
      .rsp_last       (rsp_last),
      .rsp_dropped    (rsp_dropped)
   );

endmodule

`default_nettype wire
